FILE: src/bpa_pkg.sv
package bpa_pkg;

  // Field and counter widths
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned CUR_W    = 15;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BIT_W    = 5;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_PAGE_COUNT_DEF = 32768;
  localparam int unsigned PAGE_BYTES_DEF     = 4096;

  // Register reset values
  localparam logic [CNT_W-1:0] TOTAL_RESET  = 16'd32768;
  localparam logic [CUR_W-1:0] CURSOR_RESET = 15'h00FF;

  // Configuration register indexes
  localparam logic REG_TOTAL_PAGES  = 1'b0;
  localparam logic REG_START_CURSOR = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC     = 3'd0,
    CMD_FREE      = 3'd1,
    CMD_MARK_FREE = 3'd2,
    CMD_RESERVE   = 3'd3,
    CMD_INIT      = 3'd4
  } cmd_e;

  // Outcome of scanning one bitmap word for a free page
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } scan_res_t;

endpackage

FILE: src/bpa_ram.sv
module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/bpa_scan.sv
// Masks one bitmap word to the page window [lo, hi) and finds the lowest free page.
module bpa_scan #(
  parameter int unsigned AW = 10
) (
  input  logic [bpa_pkg::WORD_W-1:0] word_i,
  input  logic [AW-1:0]              wd_idx_i,
  input  logic [bpa_pkg::CNT_W-1:0]  lo_i,
  input  logic [bpa_pkg::CNT_W-1:0]  hi_i,
  output bpa_pkg::scan_res_t         res_o
);

  logic [bpa_pkg::CNT_W-1:0]  hi_m1;
  logic [bpa_pkg::WORD_W-1:0] lo_mask;
  logic [bpa_pkg::WORD_W-1:0] hi_mask;
  logic [bpa_pkg::WORD_W-1:0] cand;

  assign hi_m1 = hi_i - bpa_pkg::CNT_W'(1);

  always_comb begin
    lo_mask = '1;
    hi_mask = '1;
    if (wd_idx_i == AW'(32'(lo_i) >> 5)) begin
      lo_mask = {bpa_pkg::WORD_W{1'b1}} << lo_i[4:0];
    end
    if (wd_idx_i == AW'(32'(hi_m1) >> 5)) begin
      hi_mask = {bpa_pkg::WORD_W{1'b1}} >> (5'd31 - hi_m1[4:0]);
    end
  end

  assign cand = ~word_i & lo_mask & hi_mask;

  // priority pick, lowest bit wins
  always_comb begin
    res_o.found = |cand;
    res_o.idx   = '0;
    for (int i = bpa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res_o.idx = bpa_pkg::BIT_W'(i);
      end
    end
  end

endmodule

FILE: src/bitmap_page_allocator_core.sv
// Channel   | Signals                                   | Transaction
// ----------+-------------------------------------------+----------------------------------
// command   | start, busy, cmd_i, address_i             | start & !busy at a rising edge
// result    | done_o, status_o, page_address_o,         | done_o high for one cycle,
//           | used_count_o, free_count_o                | taken at the edge ending it
// config    | cfg_we_i, cfg_index_i, cfg_wdata_i        | cfg_we_i at a rising edge
//
// Steps: free, mark_free and reserve go from accept through the bitmap read, the modify/write
//   and the result. Alloc reads and evaluates one bitmap word after another until a word holds
//   a free page in the window or the search ends; the bitmap read is registered. Init sweeps
//   all WORDS words, one per cycle, then reports; rejected commands report without a read.
// Reset: a clearing pass over all WORDS words (1024 by default) fills the bitmap with ones;
//   busy stays high until it ends. Config writes are taken at any time.
// Stalls: the receiver cannot stall; busy holds off the next command until its result.
module bitmap_page_allocator_core #(
  parameter int unsigned MAX_PAGE_COUNT = bpa_pkg::MAX_PAGE_COUNT_DEF,
  parameter int unsigned PAGE_BYTES     = bpa_pkg::PAGE_BYTES_DEF  // power of two
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [bpa_pkg::CMD_W-1:0]   cmd_i,
  input  logic [bpa_pkg::ADDR_W-1:0]  address_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [bpa_pkg::CNT_W-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output logic                        status_o,
  output logic [bpa_pkg::ADDR_W-1:0]  page_address_o,
  output logic [bpa_pkg::CNT_W-1:0]   used_count_o,
  output logic [bpa_pkg::CNT_W-1:0]   free_count_o
);

  localparam int unsigned WORDS      = (MAX_PAGE_COUNT + 31) / 32;
  localparam int unsigned AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned CW         = bpa_pkg::CNT_W;
  localparam logic [CW-1:0] USED_RESET =
    (32'(bpa_pkg::TOTAL_RESET) > MAX_PAGE_COUNT) ? CW'(MAX_PAGE_COUNT)
                                                  : bpa_pkg::TOTAL_RESET;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;  // fill sweep, after reset or for init
  localparam logic [1:0] S_RD    = 2'd2;  // bitmap read in flight
  localparam logic [1:0] S_EVAL  = 2'd3;  // read data back: modify and write

  // control
  logic [1:0]                   state_q, state_d;
  logic                         init_q, init_d;   // sweep was started by an init command
  logic [AW-1:0]                fill_q, fill_d;
  logic                         done_q, done_d;
  // configuration and allocator state
  logic [CW-1:0]                total_q, total_d;
  logic [bpa_pkg::CUR_W-1:0]    cursor_q, cursor_d;
  logic [CW-1:0]                used_q, used_d;
  logic [CW-1:0]                free_q, free_d;
  logic [CW-1:0]                ns_q, ns_d;
  // per-command working registers
  logic [bpa_pkg::CMD_W-1:0]    cmd_q, cmd_d;
  logic [AW-1:0]                w_q, w_d;
  logic [bpa_pkg::BIT_W-1:0]    bit_q, bit_d;
  logic [CW-1:0]                lo_q, lo_d;
  logic [CW-1:0]                hi_q, hi_d;
  logic                         wrap_q, wrap_d;   // scanning the last window
  logic                         status_q, status_d;
  logic [bpa_pkg::ADDR_W-1:0]   paddr_q, paddr_d;

  logic [CW-1:0]                tot;
  logic [bpa_pkg::ADDR_W-1:0]   pg;
  logic                         pg_ok;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [bpa_pkg::WORD_W-1:0]   ram_wdata;
  logic [bpa_pkg::WORD_W-1:0]   rdata;
  logic                         cur_bit;
  logic [AW+bpa_pkg::BIT_W-1:0] hit_page;
  bpa_pkg::scan_res_t           scan;

  assign tot   = (32'(total_q) > MAX_PAGE_COUNT) ? CW'(MAX_PAGE_COUNT) : total_q;
  assign pg    = address_i >> PAGE_SHIFT;
  assign pg_ok = pg < 32'(tot);
  assign busy  = (state_q != S_IDLE);

  bpa_ram #(
    .WIDTH (bpa_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (w_q),
    .rdata_o (rdata)
  );

  bpa_scan #(
    .AW (AW)
  ) u_scan (
    .word_i   (rdata),
    .wd_idx_i (w_q),
    .lo_i     (lo_q),
    .hi_i     (hi_q),
    .res_o    (scan)
  );

  assign cur_bit  = rdata[bit_q];
  assign hit_page = {w_q, scan.idx};

  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    fill_d    = fill_q;
    done_d    = 1'b0;
    total_d   = total_q;
    cursor_d  = cursor_q;
    used_d    = used_q;
    free_d    = free_q;
    ns_d      = ns_q;
    cmd_d     = cmd_q;
    w_d       = w_q;
    bit_d     = bit_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    wrap_d    = wrap_q;
    status_d  = status_q;
    paddr_d   = paddr_q;
    ram_we    = 1'b0;
    ram_waddr = w_q;
    ram_wdata = rdata;

    if (cfg_we_i) begin
      case (cfg_index_i)
        bpa_pkg::REG_TOTAL_PAGES:  total_d  = cfg_wdata_i;
        bpa_pkg::REG_START_CURSOR: cursor_d = cfg_wdata_i[bpa_pkg::CUR_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d    = cmd_i;
          w_d      = AW'(pg >> 5);
          bit_d    = pg[bpa_pkg::BIT_W-1:0];
          status_d = 1'b0;
          paddr_d  = '0;
          case (cmd_i)
            bpa_pkg::CMD_ALLOC: begin
              if (tot == '0) begin
                status_d = 1'b1;
                done_d   = 1'b1;
              end else if (ns_q < tot) begin
                // window from cursor to the top first
                lo_d    = ns_q;
                hi_d    = tot;
                wrap_d  = 1'b0;
                w_d     = AW'(32'(ns_q) >> 5);
                state_d = S_RD;
              end else begin
                lo_d    = '0;
                hi_d    = tot;
                wrap_d  = 1'b1;
                w_d     = '0;
                state_d = S_RD;
              end
            end
            bpa_pkg::CMD_FREE, bpa_pkg::CMD_MARK_FREE, bpa_pkg::CMD_RESERVE: begin
              if (pg_ok) begin
                state_d = S_RD;
              end else begin
                status_d = 1'b1;
                done_d   = 1'b1;
              end
            end
            bpa_pkg::CMD_INIT: begin
              init_d  = 1'b1;
              fill_d  = '0;
              state_d = S_CLEAR;
            end
            default: begin
              status_d = 1'b1;
              done_d   = 1'b1;
            end
          endcase
        end
      end

      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = fill_q;
        ram_wdata = '1;
        fill_d    = fill_q + AW'(1);
        if (fill_q == LAST_WORD) begin
          state_d = S_IDLE;
          if (init_q) begin
            used_d = tot;
            free_d = '0;
            ns_d   = CW'(cursor_q);
            done_d = 1'b1;
          end
        end
      end

      S_RD: begin
        state_d = S_EVAL;
      end

      S_EVAL: begin
        case (cmd_q)
          bpa_pkg::CMD_ALLOC: begin
            if (scan.found) begin
              ram_we    = 1'b1;
              ram_wdata = rdata | (bpa_pkg::WORD_W'(1) << scan.idx);
              used_d    = (used_q != '1) ? used_q + CW'(1) : used_q;
              free_d    = (free_q != '0) ? free_q - CW'(1) : free_q;
              ns_d      = CW'(hit_page) + CW'(1);
              paddr_d   = bpa_pkg::ADDR_W'(hit_page) << PAGE_SHIFT;
              done_d    = 1'b1;
              state_d   = S_IDLE;
            end else if (w_q == AW'(32'(hi_q - CW'(1)) >> 5)) begin
              if (!wrap_q && ns_q != '0) begin
                // wrap to page zero, scan up to the cursor
                lo_d    = '0;
                hi_d    = ns_q;
                wrap_d  = 1'b1;
                w_d     = '0;
                state_d = S_RD;
              end else begin
                status_d = 1'b1;
                done_d   = 1'b1;
                state_d  = S_IDLE;
              end
            end else begin
              w_d     = w_q + AW'(1);
              state_d = S_RD;
            end
          end
          bpa_pkg::CMD_FREE, bpa_pkg::CMD_MARK_FREE: begin
            if (cur_bit) begin
              ram_we    = 1'b1;
              ram_wdata = rdata & ~(bpa_pkg::WORD_W'(1) << bit_q);
              free_d    = (free_q != '1) ? free_q + CW'(1) : free_q;
              used_d    = (used_q != '0) ? used_q - CW'(1) : used_q;
            end else if (cmd_q == bpa_pkg::CMD_FREE) begin
              status_d = 1'b1;  // double free
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          default: begin  // reserve
            if (!cur_bit) begin
              ram_we    = 1'b1;
              ram_wdata = rdata | (bpa_pkg::WORD_W'(1) << bit_q);
              used_d    = (used_q != '1) ? used_q + CW'(1) : used_q;
              free_d    = (free_q != '0) ? free_q - CW'(1) : free_q;
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      init_q   <= 1'b0;
      fill_q   <= '0;
      done_q   <= 1'b0;
      total_q  <= bpa_pkg::TOTAL_RESET;
      cursor_q <= bpa_pkg::CURSOR_RESET;
      used_q   <= USED_RESET;
      free_q   <= '0;
      ns_q     <= CW'(bpa_pkg::CURSOR_RESET);
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      fill_q   <= fill_d;
      done_q   <= done_d;
      total_q  <= total_d;
      cursor_q <= cursor_d;
      used_q   <= used_d;
      free_q   <= free_d;
      ns_q     <= ns_d;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    w_q      <= w_d;
    bit_q    <= bit_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    wrap_q   <= wrap_d;
    status_q <= status_d;
    paddr_q  <= paddr_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign page_address_o = paddr_q;
  assign used_count_o   = used_q;
  assign free_count_o   = free_q;

  // an accepted command either holds busy or is reported on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted command neither busy nor reported");

  // a result is only reported once the engine is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // bitmap writes happen only in the fill sweep or the modify step
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_EVAL))
    else $error("bitmap write outside sweep or modify");

  // an alloc hit lies inside the current search window
  a_hit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && cmd_q == bpa_pkg::CMD_ALLOC && scan.found)
      |-> (32'(hit_page) >= 32'(lo_q) && 32'(hit_page) < 32'(hi_q)))
    else $error("alloc hit outside search window");

endmodule

FILE: dv/testbench.sv
module testbench;
  import bpa_pkg::*;

  localparam int unsigned PAGE_BYTES      = PAGE_BYTES_DEF;
  localparam int unsigned PAGE_LIMIT      = MAX_PAGE_COUNT_DEF;
  localparam int unsigned BITMAP_WORDS    = PAGE_LIMIT / WORD_W;
  // cmd codes the block must reject
  localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;

  localparam int unsigned RAND_PHASES     = 9;
  localparam int unsigned PHASE_ITEMS     = 116;
  localparam int unsigned BIG_PHASE_ITEMS = 24;
  // long enough for the worst alloc, which reads and evaluates every bitmap word
  localparam int unsigned TAIL_CYCLES     = 2 * BITMAP_WORDS + 16;
  localparam int unsigned CLK_PERIOD      = 20;
  // far above the slowest legal run, clearing pass and inits included
  localparam longint unsigned TIMEOUT_CYCLES = 8_000_000;
  localparam int unsigned MAX_REPORTS     = 200;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] page_address;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
  } alloc_result_t;

  // Shadow of the allocator: bitmap, counters, cursor and both registers.
  // Every accepted command is predicted at once; results queue up in order.
  class page_alloc_scoreboard;
    bit               page_used [PAGE_LIMIT];
    logic [CNT_W-1:0] used_total;
    logic [CNT_W-1:0] free_total;
    logic [CNT_W-1:0] next_search;
    logic [CNT_W-1:0] total_reg;
    logic [CUR_W-1:0] start_cursor;
    alloc_result_t    pending_results[$];
    int unsigned      error_count;

    function new();
      foreach (page_used[i]) page_used[i] = 1'b1;
      total_reg    = TOTAL_RESET;
      start_cursor = CURSOR_RESET;
      used_total   = (TOTAL_RESET > PAGE_LIMIT) ? CNT_W'(PAGE_LIMIT) : TOTAL_RESET;
      free_total   = '0;
      next_search  = CNT_W'(CURSOR_RESET);
      error_count  = 0;
    endfunction

    function void write_reg(logic idx, logic [CNT_W-1:0] val);
      if (idx == REG_TOTAL_PAGES) total_reg = val;
      else start_cursor = val[CUR_W-1:0];
    endfunction

    // counters saturate at both ends
    function void set_page(int unsigned pg, bit used);
      page_used[pg] = used;
      if (used) begin
        if (used_total != '1) used_total++;
        if (free_total != '0) free_total--;
      end else begin
        if (free_total != '1) free_total++;
        if (used_total != '0) used_total--;
      end
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
      int unsigned   managed;
      int unsigned   pg;
      int unsigned   hit;
      int unsigned   wrap_end;
      bit            found;
      alloc_result_t res;
      managed = (total_reg > PAGE_LIMIT) ? PAGE_LIMIT : total_reg;
      pg      = addr / PAGE_BYTES;
      res     = '0;
      hit     = 0;
      found   = 1'b0;
      case (cmd)
        CMD_ALLOC: begin
          // next fit: cursor up to the last managed page, then wrap to zero
          wrap_end = (next_search < managed) ? next_search : managed;
          for (int unsigned p = next_search; p < managed && !found; p++)
            if (!page_used[p]) begin
              found = 1'b1;
              hit   = p;
            end
          for (int unsigned p = 0; p < wrap_end && !found; p++)
            if (!page_used[p]) begin
              found = 1'b1;
              hit   = p;
            end
          if (found) begin
            set_page(hit, 1'b1);
            next_search      = CNT_W'(hit + 1);
            res.page_address = ADDR_W'(hit * PAGE_BYTES);
          end else begin
            res.status = 1'b1;
          end
        end
        CMD_FREE: begin
          if (pg >= managed || !page_used[pg]) res.status = 1'b1;
          else set_page(pg, 1'b0);
        end
        CMD_MARK_FREE: begin
          if (pg >= managed) res.status = 1'b1;
          else if (page_used[pg]) set_page(pg, 1'b0);
        end
        CMD_RESERVE: begin
          if (pg >= managed) res.status = 1'b1;
          else if (!page_used[pg]) set_page(pg, 1'b1);
        end
        CMD_INIT: begin
          foreach (page_used[i]) page_used[i] = 1'b1;
          used_total  = CNT_W'(managed);
          free_total  = '0;
          next_search = CNT_W'(start_cursor);
        end
        default: res.status = 1'b1;
      endcase
      res.used_count = used_total;
      res.free_count = free_total;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [ADDR_W-1:0] want,
                                logic [ADDR_W-1:0] seen);
      if (seen !== want) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, seen);
        error_count++;
      end
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: result with no command outstanding: expected none, actual 0x%0h",
                   $time, got);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
      compare_field("page_address", want.page_address, got.page_address);
      compare_field("used_count", ADDR_W'(want.used_count), ADDR_W'(got.used_count));
      compare_field("free_count", ADDR_W'(want.free_count), ADDR_W'(got.free_count));
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  cmd_i       = '0;
  logic [ADDR_W-1:0] address_i   = '0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_index_i = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i = '0;
  logic              done_o;
  logic              status_o;
  logic [ADDR_W-1:0] page_address_o;
  logic [CNT_W-1:0]  used_count_o;
  logic [CNT_W-1:0]  free_count_o;

  page_alloc_scoreboard sb;
  bit                   no_idle = 1'b0;  // back-to-back commands when set

  bitmap_page_allocator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .address_i     (address_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .page_address_o(page_address_o),
    .used_count_o  (used_count_o),
    .free_count_o  (free_count_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Result side: done_o marks a one-cycle result, taken at the edge ending it.
  // Reads here see pre-edge values, the same ones the block drove.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result({status_o, page_address_o, used_count_o, free_count_o});
  end

  // All tasks are entered and left just after a rising edge; every drive is NBA.
  // A transaction is taken at the first edge with start high and busy low.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // gap 0 keeps start high: no drop and rise within one step
    start     <= 1'b1;
    cmd_i     <= cmd;
    address_i <= addr;
    do @(posedge clk_i); while (busy);
    sb.note_command(cmd, addr);
  endtask

  // Drop start and sit until every predicted result is back and busy is low.
  // Always advances at least one edge so start is never re-raised in this step.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending_results.size() != 0 || busy);
  endtask

  // Both registers, one per edge; only called with the block idle.
  task automatic configure(logic [CNT_W-1:0] total, logic [CNT_W-1:0] cursor_word);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_TOTAL_PAGES;
    cfg_wdata_i <= total;
    @(posedge clk_i);
    sb.write_reg(REG_TOTAL_PAGES, total);
    cfg_index_i <= REG_START_CURSOR;
    cfg_wdata_i <= cursor_word;
    @(posedge clk_i);
    sb.write_reg(REG_START_CURSOR, cursor_word);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly pages inside the managed range, some just past it, some anywhere.
  function automatic logic [ADDR_W-1:0] pick_address(int unsigned managed);
    int unsigned pg;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom();
    if (sel == 1) pg = managed + $urandom_range(0, 2);
    else pg = (managed == 0) ? 0 : $urandom_range(0, managed - 1);
    return ADDR_W'(pg * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
  endfunction

  // Steady-state traffic; init kept rare since it sweeps the whole bitmap.
  task automatic send_random_item(int unsigned managed);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) send_command(CMD_ALLOC, $urandom());
    else if (pick < 68) send_command(CMD_FREE, pick_address(managed));
    else if (pick < 82) send_command(CMD_MARK_FREE, pick_address(managed));
    else if (pick < 94) send_command(CMD_RESERVE, pick_address(managed));
    else if (pick < 97)
      send_command(CMD_W'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST)), $urandom());
    else send_command(CMD_INIT, $urandom());
  endtask

  initial begin
    int unsigned      tot;
    logic [CUR_W-1:0] cursor;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed, reset registers: 32768 pages, cursor 255, map all used ---
    send_command(CMD_ALLOC, '0);                       // full-length scan, out of memory
    send_command(CMD_FREE, '0);                        // page 0 was used
    send_command(CMD_FREE, '0);                        // double free
    send_command(CMD_MARK_FREE, ADDR_W'(PAGE_LIMIT * PAGE_BYTES - 1));  // top page
    send_command(CMD_MARK_FREE, ADDR_W'(PAGE_LIMIT * PAGE_BYTES - 1));  // already free
    send_command(CMD_FREE, '1);                        // far out of range
    send_command(CMD_MARK_FREE, ADDR_W'(PAGE_LIMIT * PAGE_BYTES));      // one past range
    send_command(CMD_RESERVE, ADDR_W'(PAGE_LIMIT * PAGE_BYTES));
    send_command(CMD_ALLOC, '0);                       // top page, cursor ends one past the last page
    send_command(CMD_ALLOC, '0);                       // empty upward scan, wraps to page 0
    send_command(CMD_RESERVE, ADDR_W'(5 * PAGE_BYTES));        // already used
    send_command(CMD_MARK_FREE, ADDR_W'(5 * PAGE_BYTES + 7));
    send_command(CMD_RESERVE, ADDR_W'(5 * PAGE_BYTES));
    send_command(CMD_BAD_FIRST, '0);
    send_command(CMD_BAD_LAST, '1);
    send_command(CMD_INIT, '0);

    // no managed pages at all
    drain_results();
    configure('0, '0);
    send_command(CMD_INIT, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, '0);

    // total above the bitmap size, cursor at its maximum
    drain_results();
    configure('1, '1);
    send_command(CMD_INIT, '0);
    send_command(CMD_MARK_FREE, ADDR_W'(100 * PAGE_BYTES));
    send_command(CMD_ALLOC, '0);                       // cursor page used, wrap finds 100

    // single page
    drain_results();
    configure(CNT_W'(1), '0);
    send_command(CMD_INIT, '0);
    send_command(CMD_MARK_FREE, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '0);                       // out of memory

    // --- random phases, small maps so scans stay short ---
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      case ($urandom_range(0, 5))
        0:       tot = 1;
        1:       tot = WORD_W;
        2:       tot = WORD_W + 1;
        3:       tot = $urandom_range(2, 64);
        default: tot = $urandom_range(65, 400);
      endcase
      case ($urandom_range(0, 4))
        0:       cursor = '0;
        1:       cursor = '1;
        2:       cursor = CUR_W'($urandom_range(0, tot));
        3:       cursor = CUR_W'(tot + $urandom_range(0, 5));  // at or beyond total
        default: cursor = CUR_W'($urandom());
      endcase
      // bit 15 of the cursor write is not part of the register
      configure(CNT_W'(tot), {1'($urandom_range(0, 1)), cursor});
      no_idle = ($urandom_range(0, 3) == 0);
      // skipping init now and then leaves counters built for another total
      if ($urandom_range(0, 3) != 0) send_command(CMD_INIT, $urandom());
      // set-up: free about half the map, the odd page reserved again
      repeat (tot / 2 + 1) begin
        if ($urandom_range(0, 7) == 0) send_command(CMD_RESERVE, pick_address(tot));
        else send_command(CMD_MARK_FREE, pick_address(tot));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) begin
          drain_results();                             // hold off until all results are in
          no_idle = !no_idle;
        end
        send_random_item(tot);
      end
    end

    // --- a few items on the full-size map: long scans and wide addresses ---
    drain_results();
    configure(CNT_W'(PAGE_LIMIT), CNT_W'($urandom_range(0, PAGE_LIMIT - 1)));
    no_idle = 1'b0;
    send_command(CMD_INIT, '0);
    repeat (8) send_command(CMD_MARK_FREE, pick_address(PAGE_LIMIT));
    repeat (BIG_PHASE_ITEMS) send_random_item(PAGE_LIMIT);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);             // catch any stray result
    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("bitmap_page_allocator_core verification clean");
    end else begin
      $display("bitmap_page_allocator_core verification failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("bitmap_page_allocator_core verification failed");
    $finish;
  end

endmodule
